### rtl/core/nconv_pkg.sv
// Shared types and constants for the normalized 3x3 convolution core.
// No dependencies.
package nconv_pkg;

    localparam int MaxWidth = 1024;
    localparam int AddrW    = $clog2(MaxWidth);
    localparam int WidthW   = 11;
    localparam int HeightW  = 16;
    localparam int RowW     = 17;
    localparam int KrowW    = 24;
    localparam int PixW     = 8;
    localparam int OutW     = 20;
    localparam int SumW     = 20;
    localparam int CsumW    = 12;
    localparam int QW       = 19;
    localparam int CfgIdxW  = 3;

    localparam logic [CfgIdxW-1:0] RegWidth  = 3'd0;
    localparam logic [CfgIdxW-1:0] RegHeight = 3'd1;
    localparam logic [CfgIdxW-1:0] RegKtop   = 3'd2;
    localparam logic [CfgIdxW-1:0] RegKmid   = 3'd3;
    localparam logic [CfgIdxW-1:0] RegKbot   = 3'd4;

    // Commands from controller to datapath.
    typedef struct packed {
        logic       step;      // take the captured pixel through stores and window
        logic       emit_left; // column zero: emit right-edge pixel of the window
        logic       ctr_border;
        logic       last;
        logic       div_start;
        logic       out_load;  // load result register from the chosen source
    } nconv_cmd_t;

    typedef struct packed {
        logic div_done;
        logic zero_csum;
    } nconv_sts_t;

endpackage

### rtl/core/nconv_div.sv
// Restoring signed divider, one quotient bit per cycle, truncating toward zero.
// Uses nconv_pkg.
module nconv_div
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [nconv_pkg::SumW-1:0]   dividend,
    input  logic signed [nconv_pkg::CsumW-1:0]  divisor,
    output logic                                done,
    output logic signed [nconv_pkg::OutW-1:0]   quotient
);
    localparam int CntW = $clog2(nconv_pkg::QW + 1);

    logic [nconv_pkg::QW-1:0]    q_reg, q_next;
    logic [nconv_pkg::QW:0]      rem_reg, rem_next;
    logic [nconv_pkg::CsumW-1:0] den_reg, den_next;
    logic                        neg_reg, neg_next;
    logic [CntW-1:0]             cnt_reg, cnt_next;
    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [nconv_pkg::QW:0]      trial;
    logic [nconv_pkg::QW:0]      shifted;
    logic [nconv_pkg::QW-1:0]    qmag;

    always_comb
    begin
        q_next    = q_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg[nconv_pkg::QW-1:0], q_reg[nconv_pkg::QW-1]};
        trial     = shifted - {{(nconv_pkg::QW+1-nconv_pkg::CsumW){1'b0}}, den_reg};
        if (start)
        begin
            q_next    = dividend[nconv_pkg::SumW-1] ? nconv_pkg::QW'(-dividend)
                                                    : nconv_pkg::QW'(dividend);
            den_next  = divisor[nconv_pkg::CsumW-1] ? nconv_pkg::CsumW'(-divisor)
                                                    : nconv_pkg::CsumW'(divisor);
            neg_next  = dividend[nconv_pkg::SumW-1] ^ divisor[nconv_pkg::CsumW-1];
            rem_next  = '0;
            cnt_next  = CntW'(nconv_pkg::QW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[nconv_pkg::QW])
            begin
                rem_next = trial;
                q_next   = {q_reg[nconv_pkg::QW-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                q_next   = {q_reg[nconv_pkg::QW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CntW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    assign qmag     = q_reg;
    assign done     = done_reg;
    assign quotient = neg_reg ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
endmodule

### rtl/core/nconv_dp.sv
// Datapath: line stores, 3x3 window, registered MAC sum, divider, result register.
// Uses nconv_pkg and nconv_div.
module nconv_dp
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  nconv_pkg::nconv_cmd_t                 cmd,
    output nconv_pkg::nconv_sts_t                 sts,
    input  logic [nconv_pkg::AddrW-1:0]           col,
    input  logic [nconv_pkg::PixW-1:0]            pix,
    input  logic                                  pix_load,
    input  logic [nconv_pkg::KrowW-1:0]           krow [3],
    output logic [nconv_pkg::OutW-1:0]            res_pixel,
    output logic                                  res_border,
    output logic                                  res_zero,
    output logic                                  res_last
);
    logic [nconv_pkg::PixW-1:0] upper_mem [nconv_pkg::MaxWidth];
    logic [nconv_pkg::PixW-1:0] lower_mem [nconv_pkg::MaxWidth];
    logic [nconv_pkg::PixW-1:0] up_rd_reg, lo_rd_reg, pix_reg;
    logic [nconv_pkg::PixW-1:0] win_reg [3][3];
    logic signed [nconv_pkg::SumW-1:0]  sum_reg, sum_next;
    logic signed [nconv_pkg::CsumW-1:0] csum_reg, csum_next;
    logic [nconv_pkg::PixW-1:0] left_reg;
    logic signed [nconv_pkg::OutW-1:0] quo;
    logic div_done;
    logic [nconv_pkg::OutW-1:0] rp_reg;
    logic rb_reg, rz_reg, rl_reg;

    // Read both stores at the column into registers that step then uses.
    always_ff @(posedge clk)
    begin
        up_rd_reg <= upper_mem[col];
        lo_rd_reg <= lower_mem[col];
        if (pix_load)
            pix_reg <= pix;
        if (cmd.step)
        begin
            upper_mem[col] <= lo_rd_reg;
            lower_mem[col] <= pix_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < 3; a++)
                for (int b = 0; b < 3; b++)
                    win_reg[a][b] <= '0;
        end
        else if (cmd.step)
        begin
            for (int a = 0; a < 3; a++)
            begin
                win_reg[a][0] <= win_reg[a][1];
                win_reg[a][1] <= win_reg[a][2];
            end
            win_reg[0][2] <= up_rd_reg;
            win_reg[1][2] <= lo_rd_reg;
            win_reg[2][2] <= pix_reg;
        end
    end

    // Flipped-kernel sum over the window after the shift.
    always_comb
    begin
        logic signed [nconv_pkg::PixW-1:0] k;
        sum_next  = '0;
        csum_next = '0;
        for (int a = 0; a < 3; a++)
            for (int b = 0; b < 3; b++)
            begin
                k = $signed(krow[a][8*b +: 8]);
                csum_next = csum_next + nconv_pkg::CsumW'(k);
                sum_next  = sum_next + nconv_pkg::SumW'(k) *
                            nconv_pkg::SumW'($signed({1'b0, win_reg[2-a][2-b]}));
            end
    end

    always_ff @(posedge clk)
    begin
        sum_reg  <= sum_next;
        csum_reg <= csum_next;
        if (cmd.step)
            left_reg <= win_reg[1][2];
    end

    nconv_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (sum_reg),
        .divisor  (csum_reg),
        .done     (div_done),
        .quotient (quo)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            rl_reg <= cmd.last;
            if (cmd.emit_left)
            begin
                rp_reg <= nconv_pkg::OutW'(left_reg);
                rb_reg <= 1'b1;
                rz_reg <= 1'b0;
            end
            else if (cmd.ctr_border)
            begin
                rp_reg <= nconv_pkg::OutW'(win_reg[1][1]);
                rb_reg <= 1'b1;
                rz_reg <= 1'b0;
            end
            else if (csum_reg == '0)
            begin
                rp_reg <= nconv_pkg::OutW'(sum_reg);
                rb_reg <= 1'b0;
                rz_reg <= 1'b1;
            end
            else
            begin
                rp_reg <= quo;
                rb_reg <= 1'b0;
                rz_reg <= 1'b0;
            end
        end
    end

    assign sts.div_done  = div_done;
    assign sts.zero_csum = (csum_reg == '0);
    assign res_pixel  = rp_reg;
    assign res_border = rb_reg;
    assign res_zero   = rz_reg;
    assign res_last   = rl_reg;
endmodule

### rtl/core/nconv_ctrl.sv
// Controller: raster counters and sequencing of store read, window step, sum,
// divide and output. Uses nconv_pkg.
module nconv_ctrl
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    output logic                              out_valid,
    input  logic                              out_ready,
    input  logic [nconv_pkg::WidthW-1:0]      width_cfg,
    input  logic [nconv_pkg::HeightW-1:0]     height_cfg,
    input  nconv_pkg::nconv_sts_t             sts,
    output nconv_pkg::nconv_cmd_t             cmd,
    output logic [nconv_pkg::AddrW-1:0]       col,
    output logic                              pix_pad
);
    typedef enum logic [7:0] {
        S_IDLE  = 8'b00000001,
        S_READ  = 8'b00000010,
        S_STEP  = 8'b00000100,
        S_SUM   = 8'b00001000,
        S_CALC  = 8'b00010000,
        S_DIV   = 8'b00100000,
        S_OUT2  = 8'b01000000,
        S_WAIT  = 8'b10000000
    } state_t;

    state_t state_reg, state_next;
    logic [nconv_pkg::AddrW-1:0]   col_reg, col_next;
    logic [nconv_pkg::RowW-1:0]    row_reg, row_next;
    logic [nconv_pkg::AddrW-1:0]   c_reg, c_next;     // clamped column of this item
    logic [nconv_pkg::RowW-1:0]    r_reg, r_next;
    logic                          ovalid_reg, ovalid_next;
    logic                          ctr_pend_reg, ctr_pend_next;
    logic [nconv_pkg::WidthW-1:0]  w;
    logic [nconv_pkg::RowW-1:0]    h;
    logic [nconv_pkg::AddrW-1:0]   wm1;
    logic [nconv_pkg::AddrW-1:0]   c_cl;
    logic                          left_emit, ctr_emit, ctr_border;

    always_comb
    begin
        w = width_cfg;
        if (width_cfg < nconv_pkg::WidthW'(3))
            w = nconv_pkg::WidthW'(3);
        if (width_cfg > nconv_pkg::WidthW'(nconv_pkg::MaxWidth))
            w = nconv_pkg::WidthW'(nconv_pkg::MaxWidth);
        h = (height_cfg < nconv_pkg::HeightW'(3)) ? nconv_pkg::RowW'(3)
                                                 : nconv_pkg::RowW'(height_cfg);
        wm1  = nconv_pkg::AddrW'(w - 1'b1);
        c_cl = ({1'b0, col_reg} >= w) ? wm1 : col_reg;
    end

    // The right-edge column leaves through the column-zero result of the next row.
    assign left_emit  = (c_reg == '0) && (r_reg >= nconv_pkg::RowW'(2));
    assign ctr_emit   = (c_reg != '0) && (r_reg != '0);
    assign ctr_border = (r_reg == nconv_pkg::RowW'(1)) || (r_reg == h)
                      || (c_reg == nconv_pkg::AddrW'(1));

    always_comb
    begin
        state_next    = state_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        c_next        = c_reg;
        r_next        = r_reg;
        ovalid_next   = ovalid_reg;
        ctr_pend_next = ctr_pend_reg;
        cmd           = '0;
        if (ovalid_reg && out_ready)
            ovalid_next = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    c_next     = c_cl;
                    r_next     = row_reg;
                    col_next   = c_cl;
                    state_next = S_READ;
                end
            end
            S_READ:
                state_next = S_STEP;
            S_STEP:
            begin
                cmd.step = 1'b1;
                // advance the counters for the next item
                if (c_reg == '0 && r_reg >= h + 1'b1)
                begin
                    row_next = '0;
                    col_next = '0;
                end
                else if ({1'b0, c_reg} + 1'b1 >= w)
                begin
                    col_next = '0;
                    row_next = r_reg + 1'b1;
                end
                else
                begin
                    col_next = c_reg + 1'b1;
                    row_next = r_reg;
                end
                ctr_pend_next = ctr_emit;
                state_next    = S_SUM;
            end
            S_SUM:
                // wait in this state so the sum register sees the shifted window
                state_next = S_CALC;
            S_CALC:
            begin
                if (left_emit)
                    state_next = S_WAIT;
                else if (ctr_pend_reg && !ctr_border)
                    state_next = S_DIV;
                else if (ctr_pend_reg)
                    state_next = S_OUT2;
                else
                    state_next = S_IDLE;
                if (!left_emit && ctr_pend_reg && !ctr_border)
                    cmd.div_start = !sts.zero_csum;
                if (!left_emit && ctr_pend_reg && !ctr_border && sts.zero_csum)
                    state_next = S_OUT2;
            end
            S_DIV:
                if (sts.div_done)
                    state_next = S_OUT2;
            S_WAIT:
            begin
                // right-edge border result; column zero carries no center result
                if (!ovalid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    cmd.emit_left = 1'b1;
                    cmd.last = (r_reg >= h + 1'b1);
                    ovalid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_OUT2:
            begin
                if (!ovalid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.ctr_border = ctr_border;
                    ovalid_next    = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            col_reg      <= '0;
            row_reg      <= '0;
            c_reg        <= '0;
            r_reg        <= '0;
            ovalid_reg   <= 1'b0;
            ctr_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            c_reg        <= c_next;
            r_reg        <= r_next;
            ovalid_reg   <= ovalid_next;
            ctr_pend_reg <= ctr_pend_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = ovalid_reg;
    assign col       = (state_reg == S_IDLE) ? c_cl : c_reg;
    assign pix_pad   = (row_reg >= h);
endmodule

### rtl/core/normalized_3x3_image_convolution_core.sv
// Channel  | group        | payload
// input    | s_axis_*     | tdata[7:0] pixel_in
// output   | m_axis_*     | tdata[19:0] pixel_out; tuser[1:0] is_border, zero_sum; tlast frame_last
// config   | cfg_*        | index 0..4, data 24 bits
//
// One pixel per request; no new pixel is taken until the current one has passed the
// read, step, sum and decision states, plus the output state if it loads a copied pixel
// or a raw sum, reached through the 19-step bit-serial divider for an interior pixel.
// A result not yet taken from the output register holds the next load, and the input.
// Reset is asynchronous; line stores are not cleared.
// Depends on nconv_pkg, nconv_ctrl, nconv_dp, nconv_div.
module normalized_3x3_image_convolution_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] pixel_in
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [19:0] pixel_out, zero fill above
    output logic [1:0]  m_axis_tuser,   // [0] is_border, [1] zero_sum
    output logic        m_axis_tlast,   // frame_last
    input  logic        cfg_we,
    input  logic [nconv_pkg::CfgIdxW-1:0] cfg_index,
    input  logic [nconv_pkg::KrowW-1:0]   cfg_data
);
    logic [nconv_pkg::WidthW-1:0]  width_reg;
    logic [nconv_pkg::HeightW-1:0] height_reg;
    logic [nconv_pkg::KrowW-1:0]   krow_reg [3];
    nconv_pkg::nconv_cmd_t cmd;
    nconv_pkg::nconv_sts_t sts;
    logic [nconv_pkg::AddrW-1:0] col;
    logic pix_pad;
    logic [nconv_pkg::PixW-1:0] pix;
    logic [nconv_pkg::OutW-1:0] rp;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= nconv_pkg::WidthW'(640);
            height_reg  <= nconv_pkg::HeightW'(480);
            krow_reg[0] <= '0;
            krow_reg[1] <= nconv_pkg::KrowW'(256);
            krow_reg[2] <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                nconv_pkg::RegWidth:  width_reg   <= cfg_data[nconv_pkg::WidthW-1:0];
                nconv_pkg::RegHeight: height_reg  <= cfg_data[nconv_pkg::HeightW-1:0];
                nconv_pkg::RegKtop:   krow_reg[0] <= cfg_data;
                nconv_pkg::RegKmid:   krow_reg[1] <= cfg_data;
                nconv_pkg::RegKbot:   krow_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    assign pix = pix_pad ? '0 : s_axis_tdata;

    nconv_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .width_cfg  (width_reg),
        .height_cfg (height_reg),
        .sts        (sts),
        .cmd        (cmd),
        .col        (col),
        .pix_pad    (pix_pad)
    );

    nconv_dp u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .col        (col),
        .pix        (pix),
        .pix_load   (s_axis_tvalid && s_axis_tready),
        .krow       (krow_reg),
        .res_pixel  (rp),
        .res_border (m_axis_tuser[0]),
        .res_zero   (m_axis_tuser[1]),
        .res_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {4'b0, rp};
endmodule

### rtl/core/nconv_checker.sv
// Port-level checks for the convolution core, bound to the top level.
// Uses no package.
module nconv_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);
    a_one_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
        else $error("border and zero-sum together");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped while stalled");
    a_no_back: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("item taken while previous in work");
    a_border_pix: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[23:8] == 16'd0)
        else $error("border value out of pixel range");
endmodule

bind normalized_3x3_image_convolution_core nconv_checker u_chk
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

### dv/tb_normalized_3x3_image_convolution_core.sv
// Testbench for the normalized 3x3 convolution core: streams whole frames under
// several geometries and kernels, predicts each filtered or copied pixel in place.
// Depends on nconv_pkg and normalized_3x3_image_convolution_core.
module tb_normalized_3x3_image_convolution_core;
    timeunit 1ns;
    timeprecision 1ps;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        cfg_we;
    logic [nconv_pkg::CfgIdxW-1:0] cfg_index;
    logic [nconv_pkg::KrowW-1:0]   cfg_data;

    normalized_3x3_image_convolution_core uut (.*);

    typedef struct packed {
        logic [19:0] pixel;
        logic        border;
        logic        zsum;
        logic        last;
    } conv_out_t;

    // predictor state
    logic [10:0] cur_width;
    logic [15:0] cur_height;
    logic [23:0] krow [3];
    logic [7:0]  upper_line [nconv_pkg::MaxWidth];
    logic [7:0]  lower_line [nconv_pkg::MaxWidth];
    logic [7:0]  win [3][3];
    int unsigned col_cnt, row_cnt;

    conv_out_t pending_pixels[$];
    int  errors = 0;
    int  received = 0;
    int  sent = 0;
    longint cycles = 0;
    bit  no_idle = 0;

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 3000000)
        begin
            $display("%0t timeout with %0d results pending", $time, pending_pixels.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic logic signed [7:0] coef(int a, int b);
        return krow[a][8*b +: 8];
    endfunction

    task automatic predict_pixel(input logic [7:0] pin);
        int unsigned w, h, r, c, i, j;
        logic [7:0] pix;
        int sum, csum, q;
        conv_out_t o;
        w = cur_width;
        h = cur_height;
        r = row_cnt;
        c = col_cnt;
        if (w < 3) w = 3;
        if (w > nconv_pkg::MaxWidth) w = nconv_pkg::MaxWidth;
        if (h < 3) h = 3;
        if (c >= w) c = w - 1;
        pix = (r >= h) ? 8'd0 : pin;
        // column zero flushes the right-edge pixel of two rows back
        if (c == 0 && r >= 2)
        begin
            o.pixel = {12'd0, win[1][2]};
            o.border = 1'b1;
            o.zsum = 1'b0;
            o.last = (r >= h + 1);
            pending_pixels.push_back(o);
        end
        for (int a = 0; a < 3; a++)
        begin
            win[a][0] = win[a][1];
            win[a][1] = win[a][2];
        end
        win[0][2] = upper_line[c];
        win[1][2] = lower_line[c];
        win[2][2] = pix;
        upper_line[c] = lower_line[c];
        lower_line[c] = pix;
        if (c >= 1 && r >= 1)
        begin
            i = r - 1;
            j = c - 1;
            o.last = 1'b0;
            if (i == 0 || i == h - 1 || j == 0 || j == w - 1)
            begin
                o.pixel = {12'd0, win[1][1]};
                o.border = 1'b1;
                o.zsum = 1'b0;
            end
            else
            begin
                sum = 0;
                csum = 0;
                for (int a = 0; a < 3; a++)
                    for (int b = 0; b < 3; b++)
                    begin
                        csum += int'(coef(a, b));
                        sum += int'(coef(a, b)) * int'(win[2-a][2-b]);
                    end
                o.border = 1'b0;
                o.zsum = (csum == 0);
                q = (csum == 0) ? sum : sum / csum;
                o.pixel = q[19:0];
            end
            pending_pixels.push_back(o);
        end
        if (c == 0 && r >= h + 1)
        begin
            row_cnt = 0;
            col_cnt = 0;
        end
        else if (c + 1 >= w)
        begin
            col_cnt = 0;
            row_cnt = r + 1;
        end
        else
        begin
            col_cnt = c + 1;
            row_cnt = r;
        end
    endtask

    // output side: random stall, check in order
    always @(posedge clk)
    begin
        conv_out_t exp_o;
        if (m_axis_tvalid && m_axis_tready)
        begin
            received++;
            if (pending_pixels.size() == 0)
            begin
                $display("%0t unexpected result act=%h", $time, m_axis_tdata);
                errors++;
            end
            else
            begin
                exp_o = pending_pixels.pop_front();
                if (m_axis_tdata !== {4'd0, exp_o.pixel} || m_axis_tuser[0] !== exp_o.border
                    || m_axis_tuser[1] !== exp_o.zsum || m_axis_tlast !== exp_o.last)
                begin
                    $display("%0t mismatch exp pix=%h b=%b z=%b l=%b act pix=%h user=%b l=%b",
                             $time, exp_o.pixel, exp_o.border, exp_o.zsum, exp_o.last,
                             m_axis_tdata, m_axis_tuser, m_axis_tlast);
                    errors++;
                end
            end
        end
        if (rst_n)
            m_axis_tready <= no_idle || ($urandom_range(99) >= 38);
    end

    // hold valid across items; drop it only on idle cycles and when draining
    task automatic send_pixel(input logic [7:0] pin);
        while (!no_idle && $urandom_range(99) < 38)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= pin;
        do
            @(posedge clk);
        while (!s_axis_tready);
        predict_pixel(pin);
        sent++;
    endtask

    task automatic write_reg(input logic [nconv_pkg::CfgIdxW-1:0] idx,
                             input logic [23:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        case (idx)
            nconv_pkg::RegWidth:  cur_width = val[10:0];
            nconv_pkg::RegHeight: cur_height = val[15:0];
            nconv_pkg::RegKtop:   krow[0] = val;
            nconv_pkg::RegKmid:   krow[1] = val;
            nconv_pkg::RegKbot:   krow[2] = val;
            default: ;
        endcase
    endtask

    task automatic drain_results;
        s_axis_tvalid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic setup_frame(input int w, input int h, input logic [23:0] kt,
                               input logic [23:0] km, input logic [23:0] kb);
        drain_results();
        write_reg(nconv_pkg::RegWidth, 24'(w));
        write_reg(nconv_pkg::RegHeight, 24'(h));
        write_reg(nconv_pkg::RegKtop, kt);
        write_reg(nconv_pkg::RegKmid, km);
        write_reg(nconv_pkg::RegKbot, kb);
        cfg_we <= 1'b0;
    endtask

    // mode 0 random, 1 all 255, 2 all 0, 3 alternating extremes
    task automatic send_frame(input int mode);
        int unsigned w, h;
        logic [7:0] p;
        w = cur_width < 3 ? 3 : (cur_width > nconv_pkg::MaxWidth ? nconv_pkg::MaxWidth
                                                               : cur_width);
        h = cur_height < 3 ? 3 : cur_height;
        for (int n = 0; n < w * h + w + 1; n++)
        begin
            case (mode)
                1: p = 8'hFF;
                2: p = 8'h00;
                3: p = n[0] ? 8'hFF : 8'h00;
                default: p = 8'($urandom_range(255));
            endcase
            send_pixel(p);
        end
    endtask

    function automatic logic [23:0] rand_krow();
        return {8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255))};
    endfunction

    task automatic test_identity_smallest;
        setup_frame(3, 3, 24'h0, 24'h000100, 24'h0);
        send_frame(3);
    endtask

    task automatic test_extreme_kernels;
        // most negative coefficients with full-scale pixels; coefficient sum -9*128
        setup_frame(4, 3, 24'h808080, 24'h808080, 24'h808080);
        send_frame(1);
        // zero coefficient sum gives the raw sum
        setup_frame(3, 4, 24'h7F0081, 24'h000000, 24'h000000);
        send_frame(0);
    endtask

    task automatic test_clamped_geometry;
        // width and height below range are used as 3; then a long row
        setup_frame(1, 0, 24'h010101, 24'h010101, 24'h010101);
        send_frame(0);
        setup_frame(130, 3, 24'h7F7F7F, 24'h7F7F7F, 24'h7F7F7F);
        send_frame(3);
    endtask

    task automatic test_random_frames;
        int w, h;
        while (sent < 1300)
        begin
            w = $urandom_range(3, 9);
            h = $urandom_range(3, 8);
            case ($urandom_range(3))
                0: setup_frame(w, h, rand_krow(), rand_krow(), rand_krow());
                1: setup_frame(w, h, 24'h010101, 24'h010801, 24'h010101);
                2: setup_frame(w, h, 24'h00FF00, 24'hFF04FF, 24'h00FF00);
                default: setup_frame(w, h, 24'h010201, 24'h020402, 24'h010201);
            endcase
            send_frame($urandom_range(9) == 0 ? 1 : 0);
        end
    endtask

    task automatic test_no_idle;
        no_idle = 1;
        repeat (3)
        begin
            setup_frame($urandom_range(3, 12), $urandom_range(3, 6),
                        rand_krow(), rand_krow(), rand_krow());
            send_frame(0);
        end
        no_idle = 0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = nconv_pkg::RegWidth;
        cfg_data = '0;
        cur_width = 11'd640;
        cur_height = 16'd480;
        krow[0] = 24'h0;
        krow[1] = 24'h000100;
        krow[2] = 24'h0;
        for (int k = 0; k < nconv_pkg::MaxWidth; k++)
        begin
            upper_line[k] = 8'd0;
            lower_line[k] = 8'd0;
        end
        for (int a = 0; a < 3; a++)
            for (int b = 0; b < 3; b++)
                win[a][b] = 8'd0;
        col_cnt = 0;
        row_cnt = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_identity_smallest();
        test_extreme_kernels();
        test_clamped_geometry();
        test_no_idle();
        test_random_frames();
        drain_results();
        $display("Sent %0d pixels over clamped, extreme and random frames and kernels;",
                 sent);
        $display("checked %0d results, %0d errors.", received, errors);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

### files.f
rtl/core/nconv_pkg.sv
rtl/core/nconv_div.sv
rtl/core/nconv_dp.sv
rtl/core/nconv_ctrl.sv
rtl/core/normalized_3x3_image_convolution_core.sv
rtl/core/nconv_checker.sv
dv/tb_normalized_3x3_image_convolution_core.sv
